// ===== rtl/aabb_pkg.sv =====
`default_nettype none
package aabb_pkg;

  localparam int COORD_W = 32;
  localparam int ID_W    = 32;
  localparam int ROW_W   = 6;
  localparam int OP_W    = 2;
  localparam int STAT_W  = 3;

  localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
  localparam logic [OP_W-1:0] OP_SCAN  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  localparam logic [STAT_W-1:0] ST_PAIR    = 3'd0;
  localparam logic [STAT_W-1:0] ST_NO_PAIR = 3'd1;
  localparam logic [STAT_W-1:0] ST_STORED  = 3'd2;
  localparam logic [STAT_W-1:0] ST_FULL    = 3'd3;
  localparam logic [STAT_W-1:0] ST_BAD_ROW = 3'd4;

  // One stored box: entity id and its four Q16.16 edges.
  typedef struct packed {
    logic [ID_W-1:0]           id;
    logic signed [COORD_W-1:0] min_x;
    logic signed [COORD_W-1:0] min_y;
    logic signed [COORD_W-1:0] max_x;
    logic signed [COORD_W-1:0] max_y;
  } box_t;

endpackage
`default_nettype wire

// ===== rtl/aabb_ram.sv =====
`default_nettype none
module aabb_ram #(
  parameter int WIDTH = 160,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

// ===== rtl/aabb_pair_overlap_table_core.sv =====
`default_nettype none
// Table of up to MAX_BOXES axis-aligned 2D boxes held in one single-port-read
// memory, one entry per box. A request is taken when start is high and busy is
// low. Load writes the box at the next free row and gives one result (stored,
// or table full) in the cycle after the request; the table never blocks on it.
// Clear empties the table and gives no result; operation code 3 is dropped.
// Scan reads the row box, then sweeps the later rows one memory read per cycle
// and reports every partner that overlaps on both axes, edges inclusive, in
// ascending row order, marking the final result. A scan keeps busy high while
// it sweeps, paced by the one read port of the box memory, and busy falls as
// its final result appears; a bad row gives its single result in the cycle
// after the request. Results appear for exactly one cycle under out_valid and
// cannot be held off, so the receiver must take every cycle in which out_valid
// is high.
module aabb_pair_overlap_table_core #(
  parameter int MAX_BOXES = 64
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 start,
  output logic                                      busy,
  input  wire logic [aabb_pkg::OP_W-1:0]            in_operation,
  input  wire logic [aabb_pkg::ROW_W-1:0]           in_row_index,
  input  wire logic [aabb_pkg::ID_W-1:0]            in_entity_id,
  input  wire logic signed [aabb_pkg::COORD_W-1:0]  in_min_x,
  input  wire logic signed [aabb_pkg::COORD_W-1:0]  in_min_y,
  input  wire logic signed [aabb_pkg::COORD_W-1:0]  in_max_x,
  input  wire logic signed [aabb_pkg::COORD_W-1:0]  in_max_y,
  output logic                                      out_valid,
  output logic [aabb_pkg::STAT_W-1:0]               out_status,
  output logic                                      out_last_of_run,
  output logic [aabb_pkg::ID_W-1:0]                 out_first_id,
  output logic [aabb_pkg::ID_W-1:0]                 out_second_id,
  output logic signed [aabb_pkg::COORD_W-1:0]       out_first_min_x,
  output logic signed [aabb_pkg::COORD_W-1:0]       out_first_min_y,
  output logic signed [aabb_pkg::COORD_W-1:0]       out_first_max_x,
  output logic signed [aabb_pkg::COORD_W-1:0]       out_first_max_y,
  output logic signed [aabb_pkg::COORD_W-1:0]       out_second_min_x,
  output logic signed [aabb_pkg::COORD_W-1:0]       out_second_min_y,
  output logic signed [aabb_pkg::COORD_W-1:0]       out_second_max_x,
  output logic signed [aabb_pkg::COORD_W-1:0]       out_second_max_y
);

  localparam int AW    = $clog2(MAX_BOXES);
  localparam int CNT_W = $clog2(MAX_BOXES + 1);
  localparam int CMP_W = aabb_pkg::ROW_W + 1;
  localparam int BOX_W = $bits(aabb_pkg::box_t);

  // Sequencer states
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_ROW   = 2'd1;  // row box arriving, first partner read issued
  localparam logic [1:0] S_SWEEP = 2'd2;  // partners arriving one per cycle

  logic [1:0]          state_r, state_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [CNT_W-1:0]    j_r, j_nxt;          // next partner row to read
  logic                rd_v_r, rd_v_nxt;    // memory output holds a partner this cycle
  aabb_pkg::box_t      row_box_r, row_box_nxt;
  aabb_pkg::box_t      pend_r, pend_nxt;    // newest hit, held until we know if it is last
  logic                pend_v_r, pend_v_nxt;

  logic                      out_valid_r, out_valid_nxt;
  logic [aabb_pkg::STAT_W-1:0] status_r, status_nxt;
  logic                      last_r, last_nxt;
  aabb_pkg::box_t            first_r, first_nxt;
  aabb_pkg::box_t            second_r, second_nxt;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  aabb_pkg::box_t      ram_wdata;
  logic [AW-1:0]       ram_raddr;
  logic [BOX_W-1:0]    ram_rdata;
  aabb_pkg::box_t      rd_box;

  logic                accept;
  logic                table_full;
  logic                row_bad;
  logic                more;
  logic                hit;
  aabb_pkg::box_t      in_box;

  aabb_ram #(
    .WIDTH (BOX_W),
    .DEPTH (MAX_BOXES)
  ) u_box_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  assign rd_box     = aabb_pkg::box_t'(ram_rdata);
  assign accept     = start && (state_r == S_IDLE);
  assign table_full = (count_r == CNT_W'(MAX_BOXES));
  assign row_bad    = ({1'b0, in_row_index} >= CMP_W'(count_r));
  assign more       = (j_r < count_r);

  assign in_box.id    = in_entity_id;
  assign in_box.min_x = in_min_x;
  assign in_box.min_y = in_min_y;
  assign in_box.max_x = in_max_x;
  assign in_box.max_y = in_max_y;

  // Inclusive interval overlap on both axes, signed compares
  assign hit = rd_v_r && (state_r == S_SWEEP) &&
               (row_box_r.min_x <= rd_box.max_x) && (rd_box.min_x <= row_box_r.max_x) &&
               (row_box_r.min_y <= rd_box.max_y) && (rd_box.min_y <= row_box_r.max_y);

  // Append the loaded box at the next free row
  assign ram_we    = accept && (in_operation == aabb_pkg::OP_LOAD) && !table_full;
  assign ram_waddr = count_r[AW-1:0];
  assign ram_wdata = in_box;

  always_comb begin
    ram_raddr = j_r[AW-1:0];
    if (state_r == S_IDLE) begin
      ram_raddr = AW'(in_row_index);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    j_nxt         = j_r;
    rd_v_nxt      = 1'b0;
    row_box_nxt   = row_box_r;
    pend_nxt      = pend_r;
    pend_v_nxt    = pend_v_r;
    out_valid_nxt = 1'b0;
    status_nxt    = status_r;
    last_nxt      = last_r;
    first_nxt     = first_r;
    second_nxt    = second_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_operation)
            aabb_pkg::OP_LOAD: begin
              out_valid_nxt = 1'b1;
              status_nxt    = table_full ? aabb_pkg::ST_FULL : aabb_pkg::ST_STORED;
              last_nxt      = 1'b1;
              first_nxt     = in_box;
              second_nxt    = '0;
              if (!table_full) begin
                count_nxt = count_r + CNT_W'(1);
              end
            end
            aabb_pkg::OP_SCAN: begin
              if (row_bad) begin
                out_valid_nxt = 1'b1;
                status_nxt    = aabb_pkg::ST_BAD_ROW;
                last_nxt      = 1'b1;
                first_nxt     = '0;
                second_nxt    = '0;
              end else begin
                j_nxt      = CNT_W'(in_row_index) + CNT_W'(1);
                pend_v_nxt = 1'b0;
                state_nxt  = S_ROW;
              end
            end
            aabb_pkg::OP_CLEAR: begin
              count_nxt = '0;
            end
            default: begin
              // unused operation: drop it
            end
          endcase
        end
      end

      S_ROW: begin
        row_box_nxt = rd_box;
        if (more) begin
          rd_v_nxt = 1'b1;
          j_nxt    = j_r + CNT_W'(1);
        end
        state_nxt = S_SWEEP;
      end

      S_SWEEP: begin
        if (more) begin
          rd_v_nxt = 1'b1;
          j_nxt    = j_r + CNT_W'(1);
        end
        if (hit) begin
          // a newer hit exists, so the held one is not the last
          if (pend_v_r) begin
            out_valid_nxt = 1'b1;
            status_nxt    = aabb_pkg::ST_PAIR;
            last_nxt      = 1'b0;
            first_nxt     = row_box_r;
            second_nxt    = pend_r;
          end
          pend_nxt   = rd_box;
          pend_v_nxt = 1'b1;
        end else if (!rd_v_r && !more) begin
          // sweep drained: flush the held hit as last, or report no pair
          out_valid_nxt = 1'b1;
          last_nxt      = 1'b1;
          if (pend_v_r) begin
            status_nxt = aabb_pkg::ST_PAIR;
            first_nxt  = row_box_r;
            second_nxt = pend_r;
          end else begin
            status_nxt = aabb_pkg::ST_NO_PAIR;
            first_nxt  = '0;
            second_nxt = '0;
          end
          pend_v_nxt = 1'b0;
          state_nxt  = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      rd_v_r      <= 1'b0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rd_v_r      <= rd_v_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers carry no reset
  always_ff @(posedge clk) begin
    j_r       <= j_nxt;
    row_box_r <= row_box_nxt;
    pend_r    <= pend_nxt;
    status_r  <= status_nxt;
    last_r    <= last_nxt;
    first_r   <= first_nxt;
    second_r  <= second_nxt;
  end

  assign busy             = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_status       = status_r;
  assign out_last_of_run  = last_r;
  assign out_first_id     = first_r.id;
  assign out_first_min_x  = first_r.min_x;
  assign out_first_min_y  = first_r.min_y;
  assign out_first_max_x  = first_r.max_x;
  assign out_first_max_y  = first_r.max_y;
  assign out_second_id    = second_r.id;
  assign out_second_min_x = second_r.min_x;
  assign out_second_min_y = second_r.min_y;
  assign out_second_max_x = second_r.max_x;
  assign out_second_max_y = second_r.max_y;

endmodule
`default_nettype wire
